@@ rtl/kla_pkg.sv @@
// Shared types and constants for the binary-lifting k-th ancestor block.
package kla_pkg;

  localparam int NODES   = 1024;
  localparam int LEVELS  = 10;
  localparam int NODE_W  = $clog2(NODES);
  localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int ADDR_W  = LVL_W + NODE_W;
  localparam int DEPTH   = LEVELS << NODE_W;
  localparam int OP_W    = 2;
  localparam int VALUE_W = 20;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_BUILD = 2'd1,
    OP_QUERY = 2'd2
  } kla_op_t;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_BUILD = 5'b00100,
    S_QUERY = 5'b01000,
    S_DONE  = 5'b10000
  } kla_state_t;

  typedef struct packed {
    logic              clr_we;
    logic [ADDR_W-1:0] clr_addr;
    logic              load;
    logic              bld_issue;
    logic [LVL_W-1:0]  bld_lvl;
    logic [NODE_W-1:0] bld_node;
    logic              q_start;
    logic              q_step;
    logic [LVL_W-1:0]  q_lvl;
    logic              out_load;
  } kla_cmd_t;

endpackage

@@ rtl/kla_ctrl.sv @@
// Controller: clearing sweep, build sequencing, query walk and output handshake.
module kla_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic [kla_pkg::OP_W-1:0] in_operation,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output kla_pkg::kla_cmd_t      cmd
);
  import kla_pkg::*;

  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(DEPTH - 1);
  localparam logic [NODE_W:0]   N_LAST   = (NODE_W+1)'(NODES + 1);
  localparam logic [LVL_W-1:0]  LVL_TOP  = LVL_W'(LEVELS - 1);

  kla_state_t        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_r, clr_nxt;
  logic [NODE_W:0]   n_r, n_nxt;
  logic [LVL_W-1:0]  lvl_r, lvl_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              accept;
  logic              out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    n_nxt         = n_r;
    lvl_nxt       = lvl_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.clr_addr  = clr_r;
    cmd.bld_lvl   = lvl_r;
    cmd.bld_node  = n_r[NODE_W-1:0];
    cmd.q_lvl     = lvl_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_we = 1'b1;
        clr_nxt    = clr_r + ADDR_W'(1);
        if (clr_r == CLR_LAST) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          unique case (kla_op_t'(in_operation))
            OP_LOAD: begin
              cmd.load = 1'b1;
            end
            OP_BUILD: begin
              n_nxt   = '0;
              lvl_nxt = LVL_W'(1);
              if (LEVELS > 1) begin
                state_nxt = S_BUILD;
              end
            end
            OP_QUERY: begin
              cmd.q_start = 1'b1;
              lvl_nxt     = LVL_TOP;
              state_nxt   = S_QUERY;
            end
            default: begin
            end
          endcase
        end
      end
      S_BUILD: begin
        // idle slots at the end of each level drain the write pipe
        cmd.bld_issue = !n_r[NODE_W];
        n_nxt         = n_r + (NODE_W+1)'(1);
        if (n_r == N_LAST) begin
          n_nxt = '0;
          if (lvl_r == LVL_TOP) begin
            state_nxt = S_IDLE;
          end else begin
            lvl_nxt = lvl_r + LVL_W'(1);
          end
        end
      end
      S_QUERY: begin
        cmd.q_step = 1'b1;
        lvl_nxt    = lvl_r - LVL_W'(1);
        if (lvl_r == '0) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      n_r         <= '0;
      lvl_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      n_r         <= n_nxt;
      lvl_r       <= lvl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/kla_dpath.sv @@
// Datapath: ancestor table memory, build pipeline, query walk and result register.
module kla_dpath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  kla_pkg::kla_cmd_t           cmd,
  input  logic [kla_pkg::NODE_W-1:0]  in_node,
  input  logic [kla_pkg::VALUE_W-1:0] in_value,
  output logic [kla_pkg::NODE_W-1:0]  out_ancestor,
  output logic                        out_found
);
  import kla_pkg::*;

  logic [NODE_W-1:0] mem [DEPTH];

  logic [ADDR_W-1:0] addr_a, addr_b, waddr;
  logic [NODE_W-1:0] rd_a_q, rd_b_q, wdata;
  logic              we;

  // build pipeline
  logic              v1_r, v2_r;
  logic [LVL_W-1:0]  lvl1_r, lvl2_r;
  logic [NODE_W-1:0] n1_r, n2_r;

  // query walk
  logic [NODE_W-1:0] cur_r;
  logic [LEVELS-1:0] k_r;
  logic              pend_r, ok_r;
  logic [NODE_W-1:0] cur;
  logic              q_ok;
  logic [NODE_W-1:0] load_par;

  logic [NODE_W-1:0] out_anc_r;
  logic              out_found_r;

  assign cur = pend_r ? rd_a_q : cur_r;

  assign q_ok = (in_node != '0) && (int'(in_node) < NODES) &&
                ((in_value >> LEVELS) == '0);
  assign load_par = (int'(in_value) >= NODES) ? '0 : in_value[NODE_W-1:0];

  always_comb begin
    if (cmd.bld_issue) begin
      addr_a = {cmd.bld_lvl - LVL_W'(1), cmd.bld_node};
    end else begin
      addr_a = {cmd.q_lvl, cur};
    end
    addr_b = {lvl1_r - LVL_W'(1), rd_a_q};
    priority if (cmd.clr_we) begin
      we    = 1'b1;
      waddr = cmd.clr_addr;
      wdata = '0;
    end else if (cmd.load) begin
      // node zero keeps its null parent
      we    = (in_node != '0) && (int'(in_node) < NODES);
      waddr = {LVL_W'(0), in_node};
      wdata = load_par;
    end else begin
      we    = v2_r;
      waddr = {lvl2_r, n2_r};
      wdata = rd_b_q;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a_q <= mem[addr_a];
    rd_b_q <= mem[addr_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.bld_issue;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    lvl1_r <= cmd.bld_lvl;
    n1_r   <= cmd.bld_node;
    lvl2_r <= lvl1_r;
    n2_r   <= n1_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.q_start) begin
      cur_r  <= in_node;
      k_r    <= in_value[LEVELS-1:0];
      ok_r   <= q_ok;
      pend_r <= 1'b0;
    end else if (cmd.q_step) begin
      // a set bit jumps: the next step takes the node from the read data
      cur_r  <= cur;
      pend_r <= k_r[cmd.q_lvl];
    end else if (pend_r) begin
      // capture the last jump so a stalled result keeps its node
      cur_r  <= rd_a_q;
      pend_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_anc_r   <= ok_r ? cur : '0;
      out_found_r <= ok_r && (cur != '0);
    end
  end

  assign out_ancestor = out_anc_r;
  assign out_found    = out_found_r;

endmodule

@@ rtl/kth_ancestor_binary_lifting.sv @@
// Top level of the binary-lifting k-th ancestor block.
// Requests arrive on the in_ channel (valid/ready) as operation, node, value:
//   load  - writes the parent of one node into level 0 of the ancestor table
//   build - fills levels 1..LEVELS-1, each from the level below
//   query - answers the k-th ancestor of a node on the out_ channel
// Only a query produces a result; load and build produce none.
// A load is written to the table in the cycle that accepts it. A build streams
// one node per cycle through a two-read-port memory pipeline, level by level
// for LEVELS-1 levels, with idle slots at each level's end. A query walks one
// level per cycle, one table read per level, from the top level down to level
// 0; out_valid rises and in_ready returns with it, so no new query is taken
// before the result is loaded; the dependent chain of table reads sets this.
// After reset the block sweeps the ancestor table to zero, one entry a cycle,
// with in_ready low.
// The result sits in an output register; a query may be accepted while an
// earlier result waits, and the walk holds in its last step until out_ready
// frees the register.
module kth_ancestor_binary_lifting (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [kla_pkg::OP_W-1:0]    in_operation,
  input  logic [kla_pkg::NODE_W-1:0]  in_node,
  input  logic [kla_pkg::VALUE_W-1:0] in_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [kla_pkg::NODE_W-1:0]  out_ancestor,
  output logic                        out_found
);
  import kla_pkg::*;

  kla_cmd_t cmd;

  kla_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cmd          (cmd)
  );

  kla_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_node      (in_node),
    .in_value     (in_value),
    .out_ancestor (out_ancestor),
    .out_found    (out_found)
  );

  a_no_clear_while_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !cmd.clr_we)
    else $error("table clear active while accepting requests");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result register overwritten before delivery");

  a_found_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> (out_ancestor != '0))
    else $error("found result with null ancestor");

  a_build_no_request: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.bld_issue |-> !in_ready)
    else $error("request accepted during table build");

endmodule

@@ tb/kla_checker.sv @@
`timescale 1ns / 1ps
// Request/answer checker for the k-th ancestor block: mirrors the ancestor table and scores answers.
module kla_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [kla_pkg::OP_W-1:0]    in_operation,
  input  logic [kla_pkg::NODE_W-1:0]  in_node,
  input  logic [kla_pkg::VALUE_W-1:0] in_value,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [kla_pkg::NODE_W-1:0]  out_ancestor,
  input  logic                        out_found,
  output int                          fail_count,
  output int                          open_answers,
  output int                          answers_seen
);
  import kla_pkg::*;

  typedef struct packed {
    logic [NODE_W-1:0] ancestor;
    logic              found;
  } kla_answer_t;

  logic [NODE_W-1:0] lift_tbl [NODES][LEVELS];
  kla_answer_t       answer_q [$];
  int                fails;
  int                seen;

  // Fill levels 1 and up, each one from the finished level below it.
  function automatic void relift_all();
    logic [NODE_W-1:0] mid;
    for (int lvl = 1; lvl < LEVELS; lvl++) begin
      for (int n = 0; n < NODES; n++) begin
        mid = lift_tbl[n][lvl-1];
        if (int'(mid) >= NODES) mid = '0;
        lift_tbl[n][lvl] = lift_tbl[mid][lvl-1];
      end
    end
  endfunction

  function automatic kla_answer_t kth_ancestor(logic [NODE_W-1:0] node,
                                               logic [VALUE_W-1:0] k);
    kla_answer_t       ans;
    logic [NODE_W-1:0] cur;
    ans = '0;
    if (node != '0 && int'(node) < NODES && (k >> LEVELS) == '0) begin
      cur = node;
      for (int lvl = LEVELS - 1; lvl >= 0; lvl--) begin
        if (k[lvl]) cur = lift_tbl[cur][lvl];
      end
      ans.ancestor = cur;
      ans.found    = (cur != '0);
    end
    return ans;
  endfunction

  always @(posedge clk) begin : score
    kla_answer_t want;
    if (!rst_n) begin
      foreach (lift_tbl[n, l]) lift_tbl[n][l] = '0;
      answer_q.delete();
      fails = 0;
      seen  = 0;
    end else begin
      // Score the answer first: it can never belong to a query taken at this edge.
      if (out_valid && out_ready) begin
        seen++;
        if (answer_q.size() == 0) begin
          fails++;
          $error("unexpected answer: ancestor %0d found %0d", out_ancestor, out_found);
        end else begin
          want = answer_q.pop_front();
          if (out_ancestor !== want.ancestor) begin
            fails++;
            $error("ancestor: expected %0d, got %0d", want.ancestor, out_ancestor);
          end
          if (out_found !== want.found) begin
            fails++;
            $error("found: expected %0d, got %0d", want.found, out_found);
          end
        end
      end
      if (in_valid && in_ready) begin
        case (in_operation)
          OP_LOAD: begin
            if (in_node != '0 && int'(in_node) < NODES)
              lift_tbl[in_node][0] = (in_value >= NODES) ? '0 : in_value[NODE_W-1:0];
          end
          OP_BUILD: relift_all();
          OP_QUERY: answer_q.insert(answer_q.size(), kth_ancestor(in_node, in_value));
          default: ;
        endcase
      end
    end
    fail_count   <= fails;
    open_answers <= answer_q.size();
    answers_seen <= seen;
  end

endmodule

@@ tb/kth_ancestor_binary_lifting_test.sv @@
`timescale 1ns / 1ps
// Top of the k-th ancestor testbench: clock, reset, request stimulus and verdict.
module kth_ancestor_binary_lifting_test;
  import kla_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int  RANDOM_REQS = 1800;
  localparam longint LIMIT    = 4_000_000;

  logic               clk;
  logic               rst_n        = 1'b0;
  logic               in_valid     = 1'b0;
  logic               in_ready;
  logic [OP_W-1:0]    in_operation = OP_LOAD;
  logic [NODE_W-1:0]  in_node      = '0;
  logic [VALUE_W-1:0] in_value     = '0;
  logic               out_valid;
  logic               out_ready    = 1'b0;
  logic [NODE_W-1:0]  out_ancestor;
  logic               out_found;

  int     fail_count;
  int     open_answers;
  int     answers_seen;
  longint cycle_cnt = 0;
  bit     calm = 1'b0;
  int     out_hold = 0;
  int     requests_sent = 0;
  int     loads_sent = 0;
  int     builds_sent = 0;
  int     queries_sent = 0;
  int     members [$];
  int     linked  [$];

  kth_ancestor_binary_lifting dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_node      (in_node),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_ancestor (out_ancestor),
    .out_found    (out_found)
  );

  kla_checker answer_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_node      (in_node),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_ancestor (out_ancestor),
    .out_found    (out_found),
    .fail_count   (fail_count),
    .open_answers (open_answers),
    .answers_seen (answers_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("kth_ancestor_binary_lifting_test: done, errors");
      $finish;
    end
  end

  // Answer side: after each answer, drop ready at random, except in calm phases.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_valid && out_ready) out_hold = calm ? 0 : $urandom_range(0, 5);
      if (out_hold > 0) begin
        out_ready <= 1'b0;
        out_hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Entered and left at a rising edge; returns at the edge that takes the request.
  task automatic send_req(input logic [OP_W-1:0] op, input int node, input int value);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_node      <= NODE_W'(node);
    in_value     <= VALUE_W'(value);
    do @(posedge clk); while (!in_ready);
    case (op)
      OP_LOAD: if (NODE_W'(node) != '0) begin
        loads_sent++;
        requests_sent++;
      end
      OP_BUILD: begin
        builds_sent++;
        requests_sent++;
      end
      OP_QUERY: begin
        queries_sent++;
        requests_sent++;
      end
      default: ;
    endcase
  endtask

  // Hold off the sender until every outstanding query has been answered.
  task automatic drain_answers();
    in_valid <= 1'b0;
    do @(posedge clk); while (open_answers != 0);
  endtask

  initial begin
    int  rand_start;
    int  shape;
    int  span;
    int  base;
    int  parent;
    int  node;
    int  k;
    int  pick;
    bit  first;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, clamped and ignored loads, stale levels, k limits.
    send_req(OP_QUERY, 5, 0);
    send_req(OP_QUERY, 0, 0);
    send_req(OP_QUERY, 1023, 1);
    send_req(OP_LOAD, 0, 7);
    send_req(OP_LOAD, 1023, 1022);
    send_req(OP_LOAD, 1022, 512);
    send_req(OP_LOAD, 512, 1);
    send_req(OP_LOAD, 1, 0);
    send_req(OP_LOAD, 3, (1 << VALUE_W) - 1);
    send_req(OP_LOAD, 2, 2);
    send_req(OP_UNUSED, 1023, (1 << VALUE_W) - 1);
    send_req(OP_QUERY, 1023, 1);
    send_req(OP_QUERY, 1023, 2);
    send_req(OP_BUILD, 0, 0);
    send_req(OP_QUERY, 1023, 3);
    send_req(OP_QUERY, 1023, 4);
    send_req(OP_QUERY, 1023, (1 << LEVELS) - 1);
    send_req(OP_QUERY, 2, (1 << LEVELS) - 1);
    send_req(OP_QUERY, 2, 1 << LEVELS);
    send_req(OP_QUERY, 2, (1 << VALUE_W) - 1);
    send_req(OP_QUERY, 3, 1);
    send_req(OP_LOAD, 1022, 5);
    send_req(OP_QUERY, 1023, 2);
    send_req(OP_QUERY, 1023, 0);
    send_req(OP_QUERY, 1023, 1);
    drain_answers();

    // Random: grow trees, chains and cycles, lift them, then query into them.
    rand_start = requests_sent;
    first = 1'b1;
    while (requests_sent - rand_start < RANDOM_REQS) begin
      calm  = ($urandom_range(0, 3) == 0);
      shape = $urandom_range(0, 3);
      span  = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 250) : $urandom_range(2, 40);
      base  = $urandom_range(1, NODES - 1);
      members.delete();
      for (int j = 0; j < span; j++)
        members.insert(members.size(), ((base - 1 + j) % (NODES - 1)) + 1);
      for (int j = 0; j < span; j++) begin
        case (shape)
          0: begin
            if (j > 0) parent = members[j-1];
            else if (linked.size() > 0 && $urandom_range(0, 1) == 1)
              parent = linked[$urandom_range(0, linked.size() - 1)];
            else parent = 0;
          end
          1: parent = (j == 0) ? 0 : members[$urandom_range(0, j - 1)];
          2: parent = ($urandom_range(0, 7) == 0) ? members[j] : members[(j + 1) % span];
          default: parent = ($urandom_range(0, 7) == 0) ?
                            $urandom_range(NODES, (1 << VALUE_W) - 1) :
                            $urandom_range(0, NODES - 1);
        endcase
        send_req(OP_LOAD, members[j], parent);
        linked.insert(linked.size(), members[j]);
        if (linked.size() > 300) void'(linked.pop_front());
      end
      // Now and then skip the build, or patch level 0 after it.
      if ($urandom_range(0, 7) != 0) send_req(OP_BUILD, $urandom, $urandom);
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3))
          send_req(OP_LOAD, members[$urandom_range(0, span - 1)], $urandom_range(0, NODES - 1));
      end
      repeat ($urandom_range(20, 50)) begin
        pick = $urandom_range(0, 19);
        node = members[$urandom_range(0, span - 1)];
        if (pick < 12) begin
          send_req(OP_QUERY, node, $urandom_range(0, 2 * span + 2));
        end else if (pick < 15) begin
          send_req(OP_QUERY, linked[$urandom_range(0, linked.size() - 1)],
                   $urandom_range(0, (1 << LEVELS) - 1));
        end else if (pick < 17) begin
          k = 1 << $urandom_range(0, LEVELS - 1);
          send_req(OP_QUERY, node, $urandom_range(0, 1) ? k : k - 1);
        end else if (pick == 17) begin
          send_req(OP_QUERY, $urandom_range(0, NODES - 1),
                   $urandom_range(1 << LEVELS, (1 << VALUE_W) - 1));
        end else if (pick == 18) begin
          send_req(OP_QUERY, $urandom_range(0, 1) ? 0 : $urandom_range(0, NODES - 1), $urandom);
        end else begin
          if ($urandom_range(0, 1) == 1) send_req(OP_UNUSED, $urandom, $urandom);
          else send_req(OP_LOAD, 0, $urandom);
        end
      end
      if (first || $urandom_range(0, 2) == 0) drain_answers();
      first = 1'b0;
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (open_answers != 0);
    repeat (40) @(posedge clk);

    $display("covered %0d requests: %0d loads, %0d table builds, %0d queries",
             requests_sent, loads_sent, builds_sent, queries_sent);
    $display("%0d answers compared over %0d cycles", answers_seen, cycle_cnt);
    if (fail_count == 0) begin
      $display("kth_ancestor_binary_lifting_test: done, clean");
    end else begin
      $display("kth_ancestor_binary_lifting_test: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/kla_pkg.sv
rtl/kla_ctrl.sv
rtl/kla_dpath.sv
rtl/kth_ancestor_binary_lifting.sv
tb/kla_checker.sv
tb/kth_ancestor_binary_lifting_test.sv
